@@ hdl/complex_arith_unit_macros.svh @@
// Assertion macros shared by the complex arithmetic unit RTL.
// Each macro expands to one labeled concurrent assertion on clk with rst_n.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// check a property on every rising edge outside reset
`define CAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that the consequent holds in the cycle after the antecedent
`define CAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cau_pkg.sv @@
// Package for the complex arithmetic unit: operation and status codes.
// No dependencies.
`default_nettype none
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_DZ  = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  localparam int OP_W = 2;
  localparam int ST_W = 2;

endpackage
`default_nettype wire

@@ hdl/complex_arith_unit.sv @@
// Complex arithmetic unit (add, subtract, multiply, divide) on signed fixed-point parts.
// Uses cau_pkg for codes and complex_arith_unit_macros.svh for assertions.
//
// Usage:
//   Input channel in_valid/in_ready carries in_op and the operand parts in_a_real,
//   in_a_imag, in_b_real, in_b_imag. Result channel out_valid/out_ready carries
//   out_res_real, out_res_imag and out_status (0 ok, 1 divide by zero, 2 saturated).
//   Throughput: one item per cycle while no stall holds the pipeline. An item passes the
//   operand, product, combine and magnitude stages, the divider setup register, the
//   restoring divider, which produces one quotient bit per stage for PART_WIDTH + 1
//   stages, and the output register. Every op walks the same pipeline, so results leave in order.
//   Multiply and divide truncate toward zero to FRAC_BITS fraction bits; a part
//   out of range clamps to the nearest limit and flags status 2. A divide by a
//   zero operand returns zero parts with status 1.
//   When out_ready is low with a result waiting, the whole pipeline holds and
//   in_ready drops in the same cycle; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits; no state is kept
//   between items.
`default_nettype none
`include "complex_arith_unit_macros.svh"
module complex_arith_unit #(
  parameter int PART_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [cau_pkg::OP_W-1:0]     in_op,
  input  wire logic signed [PART_WIDTH-1:0] in_a_real,
  input  wire logic signed [PART_WIDTH-1:0] in_a_imag,
  input  wire logic signed [PART_WIDTH-1:0] in_b_real,
  input  wire logic signed [PART_WIDTH-1:0] in_b_imag,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [PART_WIDTH-1:0]      out_res_real,
  output logic signed [PART_WIDTH-1:0]      out_res_imag,
  output logic [cau_pkg::ST_W-1:0]          out_status
);

  localparam int PW  = PART_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW2 = 2 * PW;
  localparam int SW  = PW2 + 1;
  localparam int MW  = SW;
  localparam int QW  = PW + 1;
  localparam int NW  = MW + F;
  localparam int TW  = NW - QW;
  localparam int CW  = (TW > PW2) ? TW : PW2;

  localparam logic [MW-1:0] SAT_NEG = MW'(1) << (PW - 1);
  localparam logic [MW-1:0] SAT_POS = SAT_NEG - MW'(1);

  typedef struct packed {
    logic [cau_pkg::OP_W-1:0] op;
    logic                     dz;
    logic                     neg_r;
    logic                     neg_i;
    logic [MW-1:0]            mag_r;
    logic [MW-1:0]            mag_i;
    logic [PW2-1:0]           d;
    logic                     ov_r;
    logic                     ov_i;
    logic [PW2-1:0]           rem_r;
    logic [PW2-1:0]           rem_i;
    logic [QW-1:0]            low_r;
    logic [QW-1:0]            low_i;
    logic [QW-1:0]            q_r;
    logic [QW-1:0]            q_i;
  } div_stage_t;

  logic en;

  // stage 0: captured operands
  logic                     v0_r;
  logic [cau_pkg::OP_W-1:0] op0_r;
  logic signed [PW-1:0]     ar0_r, ai0_r, br0_r, bi0_r;

  // stage 1: products and plain sums
  logic                     v1_r;
  logic [cau_pkg::OP_W-1:0] op1_r;
  logic signed [PW2-1:0]    p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bbr_r, p_bbi_r;
  logic signed [PW:0]       sum_r1_r, sum_i1_r;

  // stage 2: combined signed parts and squared magnitude
  logic                     v2_r;
  logic [cau_pkg::OP_W-1:0] op2_r;
  logic signed [SW-1:0]     sr2_r, si2_r;
  logic [PW2-1:0]           d2_r;

  // stage 3: sign and magnitude
  logic                     v3_r;
  logic [cau_pkg::OP_W-1:0] op3_r;
  logic                     neg_r3_r, neg_i3_r;
  logic [MW-1:0]            mag_r3_r, mag_i3_r;
  logic [PW2-1:0]           d3_r;

  // divider stages
  logic [QW:0]  stg_v_r;
  div_stage_t   stg_r [QW+1];
  div_stage_t   stg_init;

  // output register
  logic                     out_valid_r;
  logic signed [PW-1:0]     res_real_r, res_imag_r;
  logic [cau_pkg::ST_W-1:0] status_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0_r <= in_op;
      ar0_r <= in_a_real;
      ai0_r <= in_a_imag;
      br0_r <= in_b_real;
      bi0_r <= in_b_imag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= op0_r;
      p_rr_r  <= PW2'(ar0_r) * PW2'(br0_r);
      p_ii_r  <= PW2'(ai0_r) * PW2'(bi0_r);
      p_ri_r  <= PW2'(ar0_r) * PW2'(bi0_r);
      p_ir_r  <= PW2'(ai0_r) * PW2'(br0_r);
      p_bbr_r <= PW2'(br0_r) * PW2'(br0_r);
      p_bbi_r <= PW2'(bi0_r) * PW2'(bi0_r);
      if (op0_r == cau_pkg::OP_SUB) begin
        sum_r1_r <= (PW+1)'(ar0_r) - (PW+1)'(br0_r);
        sum_i1_r <= (PW+1)'(ai0_r) - (PW+1)'(bi0_r);
      end else begin
        sum_r1_r <= (PW+1)'(ar0_r) + (PW+1)'(br0_r);
        sum_i1_r <= (PW+1)'(ai0_r) + (PW+1)'(bi0_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r <= op1_r;
      d2_r  <= $unsigned(p_bbr_r) + $unsigned(p_bbi_r);
      case (op1_r)
        cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
          sr2_r <= SW'(sum_r1_r);
          si2_r <= SW'(sum_i1_r);
        end
        cau_pkg::OP_MUL: begin
          sr2_r <= SW'(p_rr_r) - SW'(p_ii_r);
          si2_r <= SW'(p_ri_r) + SW'(p_ir_r);
        end
        default: begin
          sr2_r <= SW'(p_rr_r) + SW'(p_ii_r);
          si2_r <= SW'(p_ir_r) - SW'(p_ri_r);
        end
      endcase
    end
  end

  logic [MW-1:0] abs_r, abs_i;

  always_comb begin
    abs_r = sr2_r[SW-1] ? MW'(-sr2_r) : MW'(sr2_r);
    abs_i = si2_r[SW-1] ? MW'(-si2_r) : MW'(si2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3_r    <= op2_r;
      d3_r     <= d2_r;
      neg_r3_r <= sr2_r[SW-1];
      neg_i3_r <= si2_r[SW-1];
      if (op2_r == cau_pkg::OP_MUL) begin
        // truncate toward zero on the magnitude
        mag_r3_r <= abs_r >> F;
        mag_i3_r <= abs_i >> F;
      end else begin
        mag_r3_r <= abs_r;
        mag_i3_r <= abs_i;
      end
    end
  end

  // divider setup: scale the numerator, split off the top, check for quotient overflow
  logic [NW-1:0] num_r, num_i;

  always_comb begin
    num_r          = NW'(mag_r3_r) << F;
    num_i          = NW'(mag_i3_r) << F;
    stg_init.op    = op3_r;
    stg_init.dz    = (d3_r == '0);
    stg_init.neg_r = neg_r3_r;
    stg_init.neg_i = neg_i3_r;
    stg_init.mag_r = mag_r3_r;
    stg_init.mag_i = mag_i3_r;
    stg_init.d     = d3_r;
    stg_init.ov_r  = CW'(num_r[NW-1:QW]) >= CW'(d3_r);
    stg_init.ov_i  = CW'(num_i[NW-1:QW]) >= CW'(d3_r);
    stg_init.rem_r = PW2'(num_r[NW-1:QW]);
    stg_init.rem_i = PW2'(num_i[NW-1:QW]);
    stg_init.low_r = num_r[QW-1:0];
    stg_init.low_i = num_i[QW-1:0];
    stg_init.q_r   = '0;
    stg_init.q_i   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
    end else if (en) begin
      stg_v_r <= {stg_v_r[QW-1:0], v3_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0] <= stg_init;
    end
  end

  // one restoring step per stage, one quotient bit for each part
  for (genvar k = 0; k < QW; k++) begin : g_div
    div_stage_t       nxt;
    logic [PW2:0]     t_r, t_i;
    logic [PW2:0]     dx;
    logic             ge_r, ge_i;

    always_comb begin
      nxt       = stg_r[k];
      dx        = {1'b0, stg_r[k].d};
      t_r       = {stg_r[k].rem_r, stg_r[k].low_r[QW-1]};
      t_i       = {stg_r[k].rem_i, stg_r[k].low_i[QW-1]};
      ge_r      = t_r >= dx;
      ge_i      = t_i >= dx;
      nxt.rem_r = ge_r ? PW2'(t_r - dx) : PW2'(t_r);
      nxt.rem_i = ge_i ? PW2'(t_i - dx) : PW2'(t_i);
      nxt.low_r = stg_r[k].low_r << 1;
      nxt.low_i = stg_r[k].low_i << 1;
      nxt.q_r   = {stg_r[k].q_r[QW-2:0], ge_r};
      nxt.q_i   = {stg_r[k].q_i[QW-2:0], ge_i};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k+1] <= nxt;
      end
    end
  end

  // final selection, saturation and packing
  div_stage_t    fin;
  logic [MW-1:0] fmag_r, fmag_i;
  logic [PW-1:0] pack_r_nxt, pack_i_nxt;
  logic          sat_r, sat_i;
  logic [cau_pkg::ST_W-1:0] status_nxt;

  always_comb begin
    fin = stg_r[QW];
    if (fin.op == cau_pkg::OP_DIV) begin
      fmag_r = fin.ov_r ? (MW'(1) << QW) : MW'(fin.q_r);
      fmag_i = fin.ov_i ? (MW'(1) << QW) : MW'(fin.q_i);
    end else begin
      fmag_r = fin.mag_r;
      fmag_i = fin.mag_i;
    end
    sat_r = fin.neg_r ? (fmag_r > SAT_NEG) : (fmag_r > SAT_POS);
    sat_i = fin.neg_i ? (fmag_i > SAT_NEG) : (fmag_i > SAT_POS);
    if (sat_r) begin
      pack_r_nxt = fin.neg_r ? PW'(SAT_NEG) : PW'(SAT_POS);
    end else begin
      pack_r_nxt = fin.neg_r ? PW'(-fmag_r) : PW'(fmag_r);
    end
    if (sat_i) begin
      pack_i_nxt = fin.neg_i ? PW'(SAT_NEG) : PW'(SAT_POS);
    end else begin
      pack_i_nxt = fin.neg_i ? PW'(-fmag_i) : PW'(fmag_i);
    end
    status_nxt = (sat_r || sat_i) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    if (fin.op == cau_pkg::OP_DIV && fin.dz) begin
      pack_r_nxt = '0;
      pack_i_nxt = '0;
      status_nxt = cau_pkg::ST_DZ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stg_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_real_r <= pack_r_nxt;
      res_imag_r <= pack_i_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_res_real = res_real_r;
  assign out_res_imag = res_imag_r;
  assign out_status   = status_r;

  logic [QW+4:0] pipe_vld;
  assign pipe_vld = {v0_r, v1_r, v2_r, v3_r, stg_v_r};

  `CAU_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(pipe_vld),
    "pipeline valid bits moved during a stall")
  `CAU_ASSERT(a_dz_zero_parts,
    !(out_valid && out_status == cau_pkg::ST_DZ) || (out_res_real == '0 && out_res_imag == '0),
    "divide by zero result carries nonzero parts")
  `CAU_ASSERT(a_sat_at_limit,
    !(out_valid && out_status == cau_pkg::ST_SAT) ||
    (out_res_real == PW'(SAT_POS) || out_res_real == PW'(SAT_NEG) ||
     out_res_imag == PW'(SAT_POS) || out_res_imag == PW'(SAT_NEG)),
    "saturated result has no part at a limit")
  `CAU_ASSERT(a_status_code,
    !out_valid || out_status == cau_pkg::ST_OK || out_status == cau_pkg::ST_DZ ||
    out_status == cau_pkg::ST_SAT || 1'b0,
    "unused status code on output")

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking bench for complex_arith_unit: add, subtract, multiply, divide on Q8.8 parts.
// Depends on cau_pkg and the complex_arith_unit RTL; predicts each result and compares in order.
`default_nettype none
module testbench;
  import cau_pkg::*;

  localparam int PW = 16;
  localparam int FB = 8;
  localparam int LATENCY = PW + 7;

  typedef struct packed {
    logic signed [PW-1:0] re;
    logic signed [PW-1:0] im;
    status_t              st;
  } cresult_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_op = OP_ADD;
  logic signed [PW-1:0] in_a_real = '0, in_a_imag = '0, in_b_real = '0, in_b_imag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [PW-1:0] out_res_real, out_res_imag;
  logic [ST_W-1:0] out_status;

  cresult_t pending_results[$];
  int errors = 0;
  int burst_left = 0;
  bit stall_enable = 1'b1;

  complex_arith_unit uut (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Clamp an exact value to the part range; raise sat when it clamps.
  function automatic logic signed [PW-1:0] clamp_part(longint v, inout bit sat);
    longint hi, lo;
    hi = (64'sd1 <<< (PW - 1)) - 1;
    lo = -(64'sd1 <<< (PW - 1));
    if (v > hi) begin sat = 1'b1; return hi[PW-1:0]; end
    if (v < lo) begin sat = 1'b1; return lo[PW-1:0]; end
    return v[PW-1:0];
  endfunction

  // Truncate toward zero after dropping FB fraction bits.
  function automatic longint scale_down(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >>> FB;
    return (v < 0) ? -m : m;
  endfunction

  // (num * 2^FB) / d truncated toward zero, integer part capped at 2^32 before scaling.
  function automatic longint quotient(longint num, longint d);
    longint m, q, r;
    m = (num < 0) ? -num : num;
    q = m / d;
    r = m % d;
    if (q > (64'sd1 <<< 32)) q = 64'sd1 <<< 32;
    q = (q <<< FB) + ((r <<< FB) / d);
    return (num < 0) ? -q : q;
  endfunction

  function automatic cresult_t complex_result(op_t op, longint ar, longint ai,
                                              longint br, longint bi);
    cresult_t r;
    longint xr, xi, d;
    bit sat;
    sat = 1'b0;
    case (op)
      OP_ADD: begin xr = ar + br; xi = ai + bi; end
      OP_SUB: begin xr = ar - br; xi = ai - bi; end
      OP_MUL: begin
        xr = scale_down(ar * br - ai * bi);
        xi = scale_down(ar * bi + ai * br);
      end
      default: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          r.re = '0; r.im = '0; r.st = ST_DZ;
          return r;
        end
        xr = quotient(ar * br + ai * bi, d);
        xi = quotient(ai * br - ar * bi, d);
      end
    endcase
    r.re = clamp_part(xr, sat);
    r.im = clamp_part(xi, sat);
    r.st = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // Present one item, wait for acceptance; gaps between random-length bursts.
  task automatic send_item(op_t op, logic [PW-1:0] ar, logic [PW-1:0] ai,
                           logic [PW-1:0] br, logic [PW-1:0] bi);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_op <= op;
    in_a_real <= ar; in_a_imag <= ai; in_b_real <= br; in_b_imag <= bi;
    pending_results.push_back(complex_result(op, $signed(ar), $signed(ai),
                                             $signed(br), $signed(bi)));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    go_idle();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Receiver: periodic windows of random stalls, sometimes none.
  always @(negedge clk) begin
    if (!stall_enable) out_ready <= 1'b1;
    else if (($time / 2000) % 3 == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    cresult_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d st=%0d", $time,
                 out_res_real, out_res_imag, out_status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_res_real !== e.re) begin
          $display("%0t: res_real expected %0d actual %0d", $time, e.re, out_res_real);
          errors++;
        end
        if (out_res_imag !== e.im) begin
          $display("%0t: res_imag expected %0d actual %0d", $time, e.im, out_res_imag);
          errors++;
        end
        if (out_status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_status);
          errors++;
        end
      end
    end
  end

  task automatic test_extremes();
    logic [PW-1:0] vals[6];
    vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0100, 16'hff00};
    for (int o = 0; o < 4; o++) begin
      send_item(op_t'(o), vals[0], vals[1], vals[1], vals[0]);
      send_item(op_t'(o), vals[1], vals[1], vals[1], vals[1]);
      send_item(op_t'(o), vals[0], vals[0], vals[0], vals[0]);
      send_item(op_t'(o), vals[4], vals[5], vals[3], vals[4]);
    end
    // subtract by zero is plain, divide by zero flags
    send_item(OP_SUB, vals[4], vals[5], vals[2], vals[2]);
    send_item(OP_DIV, vals[4], vals[5], vals[2], vals[2]);
    send_item(OP_DIV, vals[2], vals[2], vals[2], vals[2]);
    send_item(OP_DIV, vals[1], vals[0], vals[2], 16'h0001);
    wait_drained();
  endtask

  task automatic test_random_ops();
    logic [PW-1:0] p[4];
    for (int n = 0; n < 1000; n++) begin
      foreach (p[k]) begin
        case ($urandom_range(0, 3))
          0: p[k] = PW'($urandom);
          1: p[k] = PW'($urandom_range(0, 1023) - 512);
          2: p[k] = PW'($urandom_range(0, 1) ? 16'h7fff - $urandom_range(0, 3)
                                              : 16'h8000 + $urandom_range(0, 3));
          default: p[k] = PW'($urandom_range(0, 7) - 4);
        endcase
      end
      if ($urandom_range(0, 30) == 0) begin p[2] = '0; p[3] = '0; end
      send_item(op_t'($urandom_range(0, 3)), p[0], p[1], p[2], p[3]);
      if (n == 500) begin
        wait_drained();
        stall_enable = 1'b0;
      end
      if (n == 700) stall_enable = 1'b1;
    end
    go_idle();
  endtask

  initial begin
    int guard;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_random_ops();
    guard = 0;
    while (pending_results.size() != 0 && guard < 100_000) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
